/* hdl/time_window_around_timestamp_macros.svh */
// Assertion macros used by the checker file.
`ifndef TIME_WINDOW_AROUND_TIMESTAMP_MACROS_SVH
`define TIME_WINDOW_AROUND_TIMESTAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TWA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("time window assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TWA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("time window assertion failed");

`endif

/* hdl/twa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package twa_pkg;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [5:0] OFFSET_MIN = 6'd1;
  localparam logic [5:0] OFFSET_MAX = 6'd59;

  typedef enum logic [0:0] {
    REG_MINUTES_BEFORE = 1'b0,
    REG_MINUTES_AFTER  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct packed {
    logic [11:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [11:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
    logic [5:0]  window_second;
  } window_t;

endpackage

`default_nettype wire

/* hdl/time_window_around_timestamp.sv */
`timescale 1ns / 1ps
`default_nettype none

// A timestamp taken at a clock edge passes through the input register, then the result
// register; done rises in the same cycle that its window appears at the outputs.
// Throughput: one timestamp per cycle; busy is high only during reset.
// The calendar logic between the two registers sets the clock rate.
// Reset clears the valid flags and sets both minute offsets to 1.

module time_window_around_timestamp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output logic        done,
  output logic [11:0] start_year,
  output logic [3:0]  start_month,
  output logic [4:0]  start_day,
  output logic [4:0]  start_hour,
  output logic [5:0]  start_minute,
  output logic [11:0] end_year,
  output logic [3:0]  end_month,
  output logic [4:0]  end_day,
  output logic [4:0]  end_hour,
  output logic [5:0]  end_minute,
  output logic [5:0]  window_second
);

  function automatic logic [5:0] clamp_offset(input logic [5:0] value);
    logic [5:0] result;
    if (value < twa_pkg::OFFSET_MIN) begin
      result = twa_pkg::OFFSET_MIN;
    end else if (value > twa_pkg::OFFSET_MAX) begin
      result = twa_pkg::OFFSET_MAX;
    end else begin
      result = value;
    end
    return result;
  endfunction

  logic             stamp_valid;
  twa_pkg::stamp_t  stamp;
  logic [5:0]       minutes_before;
  logic [5:0]       minutes_after;
  twa_pkg::window_t window_next;
  twa_pkg::window_t window;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      minutes_before <= twa_pkg::OFFSET_MIN;
      minutes_after  <= twa_pkg::OFFSET_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twa_pkg::REG_MINUTES_BEFORE: minutes_before <= clamp_offset(cfg_data);
        twa_pkg::REG_MINUTES_AFTER:  minutes_after  <= clamp_offset(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      stamp_valid <= start && !busy;
      done        <= stamp_valid;
    end
    if (start && !busy) begin
      stamp <= '{year: in_year, month: in_month, day: in_day, hour: in_hour,
                 minute: in_minute, second: in_second};
    end
    if (stamp_valid) begin
      window <= window_next;
    end
  end

  twa_calc u_calc (
    .stamp      (stamp),
    .min_before (minutes_before),
    .min_after  (minutes_after),
    .window     (window_next)
  );

  assign start_year    = window.start_year;
  assign start_month   = window.start_month;
  assign start_day     = window.start_day;
  assign start_hour    = window.start_hour;
  assign start_minute  = window.start_minute;
  assign end_year      = window.end_year;
  assign end_month     = window.end_month;
  assign end_day       = window.end_day;
  assign end_hour      = window.end_hour;
  assign end_minute    = window.end_minute;
  assign window_second = window.window_second;

endmodule

`default_nettype wire

/* hdl/twa_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

module twa_calc (
  input  twa_pkg::stamp_t  stamp,
  input  logic [5:0]       min_before,
  input  logic [5:0]       min_after,
  output twa_pkg::window_t window
);

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      twa_pkg::MONTH_FEB: days = leap ? 5'd29 : 5'd28;
      default: days = 5'd30;
    endcase
    return days;
  endfunction

  // Year divided by 100 through a reciprocal; exact for every 12-bit year.
  logic [24:0] year_prod;
  logic [5:0]  cent;
  logic [11:0] cent_rem;
  logic        div100;
  logic        div400;
  logic        leap;

  logic [6:0]  min_ext;
  logic        borrow;
  logic [5:0]  start_minute;
  logic [6:0]  end_sum;
  logic        carry;
  logic [4:0]  prev_days;
  logic [4:0]  cur_days;
  logic        day_over;

  always_comb begin
    year_prod = 25'(stamp.year) * 25'd5243;
    cent      = year_prod[24:19];
    cent_rem  = stamp.year - 12'(13'(cent) * 13'd100);
    div100    = (cent_rem == 12'd0);
    div400    = div100 && (cent[1:0] == 2'd0);
    leap      = ((stamp.year[1:0] == 2'd0) && !div100) || div400;

    min_ext   = {1'b0, stamp.minute};
    borrow    = (stamp.minute < min_before);
    if (borrow) begin
      start_minute = 6'(min_ext + 7'd60 - {1'b0, min_before});
    end else begin
      start_minute = stamp.minute - min_before;
    end
    end_sum   = min_ext + {1'b0, min_after};
    carry     = (end_sum > 7'd59);
    prev_days = month_days(stamp.month - 4'd1, leap);
    cur_days  = month_days(stamp.month, leap);
    day_over  = ({1'b0, stamp.day} + 6'd1) > {1'b0, cur_days};

    window.window_second = stamp.second;

    window.start_year   = stamp.year;
    window.start_month  = stamp.month;
    window.start_day    = stamp.day;
    window.start_hour   = stamp.hour;
    window.start_minute = start_minute;
    if (borrow) begin
      if (stamp.hour == 5'd0) begin
        window.start_hour = 5'd23;
        if (stamp.day < 5'd2) begin
          if (stamp.month < twa_pkg::MONTH_FEB) begin
            window.start_month = twa_pkg::MONTH_DEC;
            window.start_year  = stamp.year - 12'd1;
            window.start_day   = 5'd31;
          end else begin
            window.start_month = stamp.month - 4'd1;
            window.start_day   = prev_days;
          end
        end else begin
          window.start_day = stamp.day - 5'd1;
        end
      end else begin
        window.start_hour = stamp.hour - 5'd1;
      end
    end

    window.end_year   = stamp.year;
    window.end_month  = stamp.month;
    window.end_day    = stamp.day;
    window.end_hour   = stamp.hour;
    window.end_minute = 6'(end_sum);
    if (carry) begin
      window.end_minute = 6'(end_sum - 7'd60);
      if (stamp.hour >= 5'd23) begin
        window.end_hour = 5'd0;
        if (day_over) begin
          window.end_day = 5'd1;
          if (stamp.month >= twa_pkg::MONTH_DEC) begin
            window.end_month = twa_pkg::MONTH_JAN;
            window.end_year  = stamp.year + 12'd1;
          end else begin
            window.end_month = stamp.month + 4'd1;
          end
        end else begin
          window.end_day = stamp.day + 5'd1;
        end
      end else begin
        window.end_hour = stamp.hour + 5'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/twa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "time_window_around_timestamp_macros.svh"

module twa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [11:0] in_year,
  input logic [5:0]  in_second,
  input logic        done,
  input logic [11:0] start_year,
  input logic [11:0] end_year,
  input logic [5:0]  window_second
);

  // Every accepted beat yields exactly one result, after the input and result registers.
  `TWA_ASSERT_NXT(a_result_follows, clk, rst, start && !busy, ##1 done)
  `TWA_ASSERT_IMP(a_no_spurious, clk, rst, done, $past(start && !busy, 2))
  `TWA_ASSERT_IMP(a_second_copy, clk, rst, done, window_second == $past(in_second, 2))
  `TWA_ASSERT_IMP(a_year_moves_one, clk, rst, done,
    (start_year == $past(in_year, 2) || start_year == $past(in_year, 2) - 12'd1) &&
    (end_year == $past(in_year, 2) || end_year == $past(in_year, 2) + 12'd1))

endmodule

bind time_window_around_timestamp twa_checker u_twa_checker (.*);

`default_nettype wire

/* bench/time_window_around_timestamp_test.sv */
`timescale 1ns / 1ps

module time_window_around_timestamp_test;

  localparam int IDLE_PERCENT = 37;
  localparam int DRAIN_CYCLES = 4;
  localparam int STEADY_FIRST = 600;
  localparam int STEADY_LAST = 850;
  localparam int PHASE_STAMPS = 160;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int LAST_MINUTE = 59;
  localparam int LAST_HOUR = 23;
  localparam int DAYS_LONG_MONTH = 31;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    bit                is_write;
    twa_pkg::cfg_reg_t target;
    logic [5:0]        value;
    twa_pkg::stamp_t   stamp;
  } feed_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        done;
  logic [11:0] start_year;
  logic [3:0]  start_month;
  logic [4:0]  start_day;
  logic [4:0]  start_hour;
  logic [5:0]  start_minute;
  logic [11:0] end_year;
  logic [3:0]  end_month;
  logic [4:0]  end_day;
  logic [4:0]  end_hour;
  logic [5:0]  end_minute;
  logic [5:0]  window_second;

  feed_beat_t       stamp_feed[$];
  twa_pkg::window_t windows_due[$];
  logic [5:0]       before_minutes;
  logic [5:0]       after_minutes;
  int               quiet_cycles;
  int               stamps_taken = 0;
  int               window_errors = 0;
  bit               next_start;
  bit               next_write;
  feed_beat_t       next_beat;
  twa_pkg::window_t seen_window;
  twa_pkg::window_t due_window;

  time_window_around_timestamp uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int days_in_month(int year, int month);
    bit leap;
    leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    case (month)
      1, 3, 5, 7, 8, 10, 12: return DAYS_LONG_MONTH;
      int'(twa_pkg::MONTH_FEB): return leap ? 29 : 28;
      default: return 30;
    endcase
  endfunction

  function automatic logic [5:0] clamp_offset(logic [5:0] raw);
    if (raw < twa_pkg::OFFSET_MIN) return twa_pkg::OFFSET_MIN;
    if (raw > twa_pkg::OFFSET_MAX) return twa_pkg::OFFSET_MAX;
    return raw;
  endfunction

  function automatic twa_pkg::window_t window_of(twa_pkg::stamp_t s, logic [5:0] early,
                                                 logic [5:0] late);
    int y, mo, d, h, mi, early_i, late_i;
    twa_pkg::window_t w;
    y = int'(s.year);
    mo = int'(s.month);
    d = int'(s.day);
    h = int'(s.hour);
    mi = int'(s.minute);
    early_i = int'(early);
    late_i = int'(late);
    w.start_year = s.year;
    w.start_month = s.month;
    w.start_day = s.day;
    w.start_hour = s.hour;
    w.end_year = s.year;
    w.end_month = s.month;
    w.end_day = s.day;
    w.end_hour = s.hour;
    w.window_second = s.second;

    if (mi < early_i) begin
      w.start_minute = 6'(mi + MINUTES_PER_HOUR - early_i);
      if (h < 1) begin
        w.start_hour = 5'(LAST_HOUR);
        if (d < 2) begin
          if (mo < int'(twa_pkg::MONTH_FEB)) begin
            w.start_month = twa_pkg::MONTH_DEC;
            w.start_year = 12'(y - 1);
            w.start_day = 5'(DAYS_LONG_MONTH);
          end else begin
            w.start_month = 4'(mo - 1);
            w.start_day = 5'(days_in_month(y, mo - 1));
          end
        end else begin
          w.start_day = 5'(d - 1);
        end
      end else begin
        w.start_hour = 5'(h - 1);
      end
    end else begin
      w.start_minute = 6'(mi - early_i);
    end

    if (mi + late_i > LAST_MINUTE) begin
      w.end_minute = 6'(mi + late_i - MINUTES_PER_HOUR);
      if (h + 1 > LAST_HOUR) begin
        w.end_hour = 5'd0;
        if (d + 1 > days_in_month(y, mo)) begin
          w.end_day = 5'd1;
          if (mo + 1 > int'(twa_pkg::MONTH_DEC)) begin
            w.end_month = twa_pkg::MONTH_JAN;
            w.end_year = 12'(y + 1);
          end else begin
            w.end_month = 4'(mo + 1);
          end
        end else begin
          w.end_day = 5'(d + 1);
        end
      end else begin
        w.end_hour = 5'(h + 1);
      end
    end else begin
      w.end_minute = 6'(mi + late_i);
    end
    return w;
  endfunction

  function automatic string window_text(twa_pkg::window_t w);
    return $sformatf("%0d-%0d-%0d %0d:%0d .. %0d-%0d-%0d %0d:%0d sec %0d",
                     w.start_year, w.start_month, w.start_day, w.start_hour,
                     w.start_minute, w.end_year, w.end_month, w.end_day, w.end_hour,
                     w.end_minute, w.window_second);
  endfunction

  task automatic queue_stamp(int y, int mo, int d, int h, int mi, int s);
    feed_beat_t b;
    b.is_write = 1'b0;
    b.target = twa_pkg::REG_MINUTES_BEFORE;
    b.value = '0;
    b.stamp = '{year: 12'(y), month: 4'(mo), day: 5'(d), hour: 5'(h), minute: 6'(mi),
                second: 6'(s)};
    stamp_feed.push_back(b);
  endtask

  task automatic queue_write(twa_pkg::cfg_reg_t target, logic [5:0] value);
    feed_beat_t b;
    b.is_write = 1'b1;
    b.target = target;
    b.value = value;
    b.stamp = '0;
    stamp_feed.push_back(b);
  endtask

  task automatic queue_random(int count);
    int y, mo, d, h, mi, len;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        queue_stamp($urandom_range(4095), $urandom_range(15), $urandom_range(31),
                    $urandom_range(31), $urandom_range(63), $urandom_range(63));
      end else begin
        case ($urandom_range(3))
          0: y = $urandom_range(4095);
          1: y = 100 * $urandom_range(40);
          2: y = 1900 + $urandom_range(200);
          default: y = 4 * $urandom_range(1023);
        endcase
        mo = ($urandom_range(3) == 0) ? int'(twa_pkg::MONTH_FEB) : $urandom_range(12, 1);
        len = days_in_month(y, mo);
        case ($urandom_range(9))
          0, 1, 2: d = 1;
          3, 4, 5: d = len;
          default: d = $urandom_range(len, 1);
        endcase
        case ($urandom_range(9))
          0, 1, 2: h = 0;
          3, 4, 5: h = LAST_HOUR;
          default: h = $urandom_range(LAST_HOUR);
        endcase
        case ($urandom_range(9))
          0, 1: mi = 0;
          2: mi = LAST_MINUTE;
          default: mi = $urandom_range(LAST_MINUTE);
        endcase
        queue_stamp(y, mo, d, h, mi, $urandom_range(59));
      end
    end
  endtask

  // A beat is held until the block takes it; register writes wait for an idle block.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      before_minutes = twa_pkg::OFFSET_MIN;
      after_minutes = twa_pkg::OFFSET_MIN;
      quiet_cycles = 0;
    end else begin
      if (start && !busy) begin
        windows_due.push_back(window_of({in_year, in_month, in_day, in_hour, in_minute,
                                         in_second}, before_minutes, after_minutes));
        stamps_taken++;
        quiet_cycles = 0;
      end else if (quiet_cycles < DRAIN_CYCLES) begin
        quiet_cycles++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == twa_pkg::REG_MINUTES_BEFORE) begin
          before_minutes = clamp_offset(cfg_data);
        end else begin
          after_minutes = clamp_offset(cfg_data);
        end
      end
      if (!(start && busy) && !(cfg_valid && !cfg_ready)) begin
        next_start = 1'b0;
        next_write = 1'b0;
        if (stamp_feed.size() > 0) begin
          if (stamp_feed[0].is_write) begin
            if (windows_due.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
              next_write = 1'b1;
              next_beat = stamp_feed.pop_front();
            end
          end else if ((stamps_taken >= STEADY_FIRST && stamps_taken < STEADY_LAST) ||
                       $urandom_range(99) >= IDLE_PERCENT) begin
            next_start = 1'b1;
            next_beat = stamp_feed.pop_front();
          end
        end
        start <= next_start;
        cfg_valid <= next_write;
        if (next_start) begin
          in_year <= next_beat.stamp.year;
          in_month <= next_beat.stamp.month;
          in_day <= next_beat.stamp.day;
          in_hour <= next_beat.stamp.hour;
          in_minute <= next_beat.stamp.minute;
          in_second <= next_beat.stamp.second;
        end
        if (next_write) begin
          cfg_index <= next_beat.target;
          cfg_data <= next_beat.value;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_window = {start_year, start_month, start_day, start_hour, start_minute,
                     end_year, end_month, end_day, end_hour, end_minute, window_second};
      if (windows_due.size() == 0) begin
        window_errors++;
        if (window_errors <= REPORT_LIMIT) begin
          $display("unexpected window: %s", window_text(seen_window));
        end
      end else begin
        due_window = windows_due.pop_front();
        if (seen_window !== due_window) begin
          window_errors++;
          if (window_errors <= REPORT_LIMIT) begin
            $display("window mismatch: expected %s, got %s", window_text(due_window),
                     window_text(seen_window));
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = twa_pkg::REG_MINUTES_BEFORE;
    cfg_data = '0;
    in_year = '0;
    in_month = '0;
    in_day = '0;
    in_hour = '0;
    in_minute = '0;
    in_second = '0;

    // Reset offsets of one minute each.
    queue_stamp(2000, 1, 1, 0, 0, 0);
    queue_stamp(0, 1, 1, 0, 0, 17);
    queue_stamp(4095, 12, 31, 23, 59, 59);
    queue_stamp(2000, 2, 28, 23, 59, 30);
    queue_stamp(2000, 2, 29, 23, 59, 1);
    queue_stamp(1900, 2, 28, 23, 59, 2);
    queue_stamp(2024, 3, 1, 0, 0, 3);
    queue_stamp(2023, 3, 1, 0, 0, 4);
    queue_stamp(2100, 3, 1, 0, 0, 5);
    queue_stamp(2023, 4, 30, 23, 59, 6);
    queue_stamp(2023, 5, 1, 0, 0, 7);
    queue_stamp(2023, 1, 31, 23, 59, 8);
    queue_stamp(2023, 7, 1, 0, 0, 9);
    queue_stamp(2023, 6, 15, 12, 30, 10);
    queue_stamp(1, 1, 1, 0, 0, 11);
    queue_stamp(1999, 0, 1, 0, 0, 12);
    queue_stamp(1999, 15, 31, 23, 63, 13);
    queue_stamp(1999, 13, 1, 0, 0, 14);
    queue_stamp(1999, 6, 0, 0, 0, 15);
    queue_stamp(1999, 7, 31, 31, 63, 16);
    queue_stamp(1999, 8, 10, 24, 0, 18);
    queue_stamp(4095, 15, 31, 31, 63, 63);
    queue_stamp(0, 0, 0, 0, 0, 0);
    queue_stamp(2023, 12, 31, 22, 59, 19);

    queue_write(twa_pkg::REG_MINUTES_BEFORE, twa_pkg::OFFSET_MAX);
    queue_write(twa_pkg::REG_MINUTES_AFTER, twa_pkg::OFFSET_MAX);
    queue_random(PHASE_STAMPS);
    queue_write(twa_pkg::REG_MINUTES_BEFORE, 6'd0);
    queue_write(twa_pkg::REG_MINUTES_AFTER, 6'd63);
    queue_random(PHASE_STAMPS);
    queue_write(twa_pkg::REG_MINUTES_BEFORE, 6'd60);
    queue_write(twa_pkg::REG_MINUTES_AFTER, 6'd0);
    queue_random(PHASE_STAMPS);
    for (int p = 0; p < 6; p++) begin
      queue_write(twa_pkg::REG_MINUTES_AFTER, 6'($urandom_range(63)));
      queue_write(twa_pkg::REG_MINUTES_BEFORE, 6'($urandom_range(63)));
      queue_random(PHASE_STAMPS);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (stamp_feed.size() > 0 || start || cfg_valid || windows_due.size() > 0) begin
      @(negedge clk);
    end
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    if (windows_due.size() > 0) begin
      $display("%0d expected windows never arrived", windows_due.size());
      window_errors += windows_due.size();
    end
    if (window_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
